@@ src/crp_pkg.sv @@
package crp_pkg;

    // Q16.16 data path
    localparam int DATA_W   = 32;
    localparam int Q_FRAC   = 16;
    localparam int WIDE_W   = 2 * DATA_W;
    localparam int GAMMA_W  = 18;
    localparam int GM1_W    = GAMMA_W + 1;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;
    localparam logic signed [GM1_W-1:0] ONE_Q = 19'sd65536;

    // RT / p divider: 48-bit dividend, two quotient bits per stage
    localparam int DIVIDEND_W = DATA_W + Q_FRAC;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = DIVIDEND_W / DIV_STEP;

    // stream widths
    localparam int IN_TDATA_W  = 8 * DATA_W;
    localparam int OUT_TDATA_W = 4 * DATA_W;
    localparam int NUM_TERMS   = 12;

    typedef logic signed [DATA_W-1:0] q_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam q_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // state carried through the first stages
    typedef struct packed {
        q_t                      p;
        q_t                      u;
        q_t                      v;
        q_t                      rt;
        q_t                      a0;
        q_t                      a1;
        q_t                      a2;
        q_t                      a3;
        logic signed [GM1_W-1:0] gm1;
    } front_t;

    // state carried alongside the divider and after it
    typedef struct packed {
        q_t                      u;
        q_t                      v;
        q_t                      a0;
        q_t                      a1;
        q_t                      a2;
        q_t                      a3;
        q_t                      d00;
        q_t                      d01;
        q_t                      d02;
        logic signed [GM1_W-1:0] gm1;
        q_t                      t;
        logic                    neg;
        logic                    err;
    } carry_t;

    // saturate a wide signed value to Q16.16
    function automatic q_t sat_wide(input wide_t x);
        wide_t hi;
        wide_t lo;
        hi = WIDE_W'(Q_MAX);
        lo = WIDE_W'(Q_MIN);
        if (x > hi)
            return Q_MAX;
        else if (x < lo)
            return Q_MIN;
        else
            return x[DATA_W-1:0];
    endfunction

    // floor of a raw product by 2^16, saturated
    function automatic q_t qmul_sat(input wide_t prod);
        return sat_wide(prod >>> Q_FRAC);
    endfunction

    // saturated negation
    function automatic q_t neg_sat(input q_t x);
        if (x == Q_MIN)
            return Q_MAX;
        else
            return -x;
    endfunction

endpackage

@@ src/crp_div.sv @@
// Pipelined restoring divider, unsigned magnitudes, two quotient bits per stage.
module crp_div (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [crp_pkg::DIVIDEND_W-1:0]       dividend,
    input  logic [crp_pkg::DATA_W-1:0]           divisor,
    output logic [crp_pkg::DIVIDEND_W-1:0]       quotient
);

    logic [crp_pkg::DATA_W-1:0]     rem_reg  [crp_pkg::DIV_STAGES];
    logic [crp_pkg::DIVIDEND_W-1:0] dq_reg   [crp_pkg::DIV_STAGES];
    logic [crp_pkg::DATA_W-1:0]     dvs_reg  [crp_pkg::DIV_STAGES];

    logic [crp_pkg::DATA_W-1:0]     rem_src  [crp_pkg::DIV_STAGES];
    logic [crp_pkg::DIVIDEND_W-1:0] dq_src   [crp_pkg::DIV_STAGES];
    logic [crp_pkg::DATA_W-1:0]     dvs_src  [crp_pkg::DIV_STAGES];

    logic [crp_pkg::DATA_W-1:0]     rem_next [crp_pkg::DIV_STAGES];
    logic [crp_pkg::DIVIDEND_W-1:0] dq_next  [crp_pkg::DIV_STAGES];

    for (genvar k = 0; k < crp_pkg::DIV_STAGES; k++)
    begin : g_stage
        // stage inputs
        if (k == 0)
        begin : g_first
            assign rem_src[k] = '0;
            assign dq_src[k]  = dividend;
            assign dvs_src[k] = divisor;
        end
        else
        begin : g_rest
            assign rem_src[k] = rem_reg[k-1];
            assign dq_src[k]  = dq_reg[k-1];
            assign dvs_src[k] = dvs_reg[k-1];
        end

        // shift in dividend bits, quotient bits fill from the bottom
        always_comb
        begin
            logic [crp_pkg::DATA_W:0]       r;
            logic [crp_pkg::DATA_W-1:0]     rm;
            logic [crp_pkg::DIVIDEND_W-1:0] dq;
            rm = rem_src[k];
            dq = dq_src[k];
            r  = '0;
            for (int i = 0; i < crp_pkg::DIV_STEP; i++)
            begin
                r  = {rm, dq[crp_pkg::DIVIDEND_W-1]};
                dq = {dq[crp_pkg::DIVIDEND_W-2:0], 1'b0};
                if (r >= {1'b0, dvs_src[k]})
                begin
                    r     = r - {1'b0, dvs_src[k]};
                    dq[0] = 1'b1;
                end
                rm = r[crp_pkg::DATA_W-1:0];
            end
            rem_next[k] = rm;
            dq_next[k]  = dq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < crp_pkg::DIV_STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                dq_reg[k]  <= dq_next[k];
                dvs_reg[k] <= dvs_src[k];
            end
        end
    end

    assign quotient = dq_reg[crp_pkg::DIV_STAGES-1];

endmodule

@@ src/conservative_to_primitive_residual.sv @@
// Converts a point's conservative residual (mass, x/y momentum, energy) into a
// primitive residual (pressure, x/y velocity, RT) through the 2D Euler Jacobian
// built from the point's p, u, v, RT and the gamma_ratio register. All values are
// signed Q16.16 and saturate. Fully pipelined, with 4 front stages, 24 stages of
// the RT/p divider at two quotient bits per stage and 6 back stages: one point
// per cycle while the output is not stalled. A stall at the output holds the
// whole pipeline. If p or RT is zero the result is zero with tuser (divide error)
// set. Write gamma_ratio only while the pipeline is empty.
module conservative_to_primitive_residual (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration: gamma_ratio
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [crp_pkg::GAMMA_W-1:0]         cfg_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pressure, x_velocity, y_velocity, gas_rt, res_mass, res_xmom, res_ymom,
    // res_energy, 32 bits each, lowest first
    input  logic [crp_pkg::IN_TDATA_W-1:0]      s_tdata,
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_pressure, out_xvel, out_yvel, out_rt, 32 bits each, lowest first
    output logic [crp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // divide_error
    output logic [0:0]                          m_tuser
);

    localparam int W = crp_pkg::DATA_W;

    logic en;
    logic [crp_pkg::GAMMA_W-1:0] gamma_reg;

    // control
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic aux_v_reg [crp_pkg::DIV_STAGES];
    logic ve1_reg, ve2_reg, ve3_reg, ve4_reg, ve5_reg, m_valid_reg;

    // front stages
    crp_pkg::front_t f0_reg, f1_reg, f2_reg, f3_reg;
    crp_pkg::front_t f0_next;
    logic [crp_pkg::WIDE_W-1:0] uu_reg, vv_reg;
    crp_pkg::wide_t ug_reg, vg_reg;
    crp_pkg::q_t ke_reg, d01_reg, d02_reg, d00_reg, t_reg;

    // divider
    crp_pkg::carry_t carry_in;
    crp_pkg::carry_t aux_reg [crp_pkg::DIV_STAGES];
    logic [crp_pkg::DIVIDEND_W-1:0] dividend;
    logic [W-1:0] p_mag, rt_mag;
    logic [crp_pkg::DIVIDEND_W-1:0] quot;

    // back stages
    crp_pkg::carry_t pe1_reg, pe2_reg, pe3_reg;
    crp_pkg::q_t ir_next;
    crp_pkg::q_t ir1_reg, ir2_reg, ir3_reg;
    crp_pkg::wide_t pui_reg, pvi_reg, pti_reg, p01i_reg, p02i_reg, pgi_reg;
    crp_pkg::q_t d10_reg, d20_reg, d30_reg, d31_reg, d32_reg, d33_reg;
    crp_pkg::wide_t prod_reg [crp_pkg::NUM_TERMS];
    crp_pkg::q_t term_reg [crp_pkg::NUM_TERMS];
    logic err4_reg, err5_reg;
    logic [crp_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic m_tuser_reg;

    // the pipeline advances unless the output holds an untaken transaction
    assign en        = !m_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gamma_reg <= crp_pkg::GAMMA_RESET;
        else if (cfg_valid && cfg_ready)
            gamma_reg <= cfg_data;
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            for (int k = 0; k < crp_pkg::DIV_STAGES; k++)
                aux_v_reg[k] <= 1'b0;
            ve1_reg     <= 1'b0;
            ve2_reg     <= 1'b0;
            ve3_reg     <= 1'b0;
            ve4_reg     <= 1'b0;
            ve5_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            aux_v_reg[0] <= v3_reg;
            for (int k = 1; k < crp_pkg::DIV_STAGES; k++)
                aux_v_reg[k] <= aux_v_reg[k-1];
            ve1_reg     <= aux_v_reg[crp_pkg::DIV_STAGES-1];
            ve2_reg     <= ve1_reg;
            ve3_reg     <= ve2_reg;
            ve4_reg     <= ve3_reg;
            ve5_reg     <= ve4_reg;
            m_valid_reg <= ve5_reg;
        end
    end

    // unpack input transaction
    always_comb
    begin
        f0_next.p   = s_tdata[0*W +: W];
        f0_next.u   = s_tdata[1*W +: W];
        f0_next.v   = s_tdata[2*W +: W];
        f0_next.rt  = s_tdata[3*W +: W];
        f0_next.a0  = s_tdata[4*W +: W];
        f0_next.a1  = s_tdata[5*W +: W];
        f0_next.a2  = s_tdata[6*W +: W];
        f0_next.a3  = s_tdata[7*W +: W];
        f0_next.gm1 = $signed({1'b0, gamma_reg}) - crp_pkg::ONE_Q;
    end

    // front stages: squares, gm1 products, kinetic energy, row 0
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [W-1:0] ua;
            logic [W-1:0] va;
            logic [crp_pkg::WIDE_W-1:0] ssum;
            logic [crp_pkg::WIDE_W-1:0] ssh;
            crp_pkg::q_t gk;
            ua = f0_reg.u[W-1] ? (~f0_reg.u + 1'b1) : f0_reg.u;
            va = f0_reg.v[W-1] ? (~f0_reg.v + 1'b1) : f0_reg.v;
            ssum = uu_reg + vv_reg;
            ssh  = ssum >> (crp_pkg::Q_FRAC + 1);
            gk   = crp_pkg::qmul_sat(crp_pkg::WIDE_W'(ke_reg) * crp_pkg::WIDE_W'(f2_reg.gm1));

            // stage 0
            f0_reg <= f0_next;
            // stage 1
            f1_reg <= f0_reg;
            uu_reg <= crp_pkg::WIDE_W'(ua) * crp_pkg::WIDE_W'(ua);
            vv_reg <= crp_pkg::WIDE_W'(va) * crp_pkg::WIDE_W'(va);
            // stage 2
            f2_reg  <= f1_reg;
            ke_reg  <= (ssh > crp_pkg::WIDE_W'(crp_pkg::Q_MAX)) ? crp_pkg::Q_MAX
                                                                 : ssh[W-1:0];
            ug_reg  <= crp_pkg::WIDE_W'(f1_reg.u) * crp_pkg::WIDE_W'(f1_reg.gm1);
            vg_reg  <= crp_pkg::WIDE_W'(f1_reg.v) * crp_pkg::WIDE_W'(f1_reg.gm1);
            // stage 3
            f3_reg  <= f2_reg;
            d00_reg <= gk;
            t_reg   <= crp_pkg::sat_wide(crp_pkg::WIDE_W'(gk) - crp_pkg::WIDE_W'(f2_reg.rt));
            d01_reg <= crp_pkg::neg_sat(crp_pkg::qmul_sat(ug_reg));
            d02_reg <= crp_pkg::neg_sat(crp_pkg::qmul_sat(vg_reg));
        end
    end

    // divider operands and side data
    always_comb
    begin
        rt_mag   = f3_reg.rt[W-1] ? (~f3_reg.rt + 1'b1) : f3_reg.rt;
        p_mag    = f3_reg.p[W-1] ? (~f3_reg.p + 1'b1) : f3_reg.p;
        dividend = {rt_mag, {crp_pkg::Q_FRAC{1'b0}}};

        carry_in.u   = f3_reg.u;
        carry_in.v   = f3_reg.v;
        carry_in.a0  = f3_reg.a0;
        carry_in.a1  = f3_reg.a1;
        carry_in.a2  = f3_reg.a2;
        carry_in.a3  = f3_reg.a3;
        carry_in.d00 = d00_reg;
        carry_in.d01 = d01_reg;
        carry_in.d02 = d02_reg;
        carry_in.gm1 = f3_reg.gm1;
        carry_in.t   = t_reg;
        carry_in.neg = f3_reg.rt[W-1] ^ f3_reg.p[W-1];
        carry_in.err = (f3_reg.p == '0) || (f3_reg.rt == '0);
    end

    crp_div u_div (
        .clk      (clk),
        .en       (en),
        .dividend (dividend),
        .divisor  (p_mag),
        .quotient (quot)
    );

    // side data delay matching the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aux_reg[0] <= carry_in;
            for (int k = 1; k < crp_pkg::DIV_STAGES; k++)
                aux_reg[k] <= aux_reg[k-1];
        end
    end

    // signed, saturated RT/p
    always_comb
    begin
        if (!aux_reg[crp_pkg::DIV_STAGES-1].neg)
        begin
            if (quot > crp_pkg::DIVIDEND_W'(crp_pkg::Q_MAX))
                ir_next = crp_pkg::Q_MAX;
            else
                ir_next = quot[W-1:0];
        end
        else
        begin
            if (quot >= {{(crp_pkg::DIVIDEND_W-W){1'b0}}, crp_pkg::Q_MIN})
                ir_next = crp_pkg::Q_MIN;
            else
                ir_next = -$signed(quot[W-1:0]);
        end
    end

    // back stages: products with ir, Jacobian rows, residual products, sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crp_pkg::wide_t s0, s1, s2, s3;
            s0 = crp_pkg::WIDE_W'(term_reg[0]) + crp_pkg::WIDE_W'(term_reg[1])
               + crp_pkg::WIDE_W'(term_reg[2]) + crp_pkg::WIDE_W'(term_reg[3]);
            s1 = crp_pkg::WIDE_W'(term_reg[4]) + crp_pkg::WIDE_W'(term_reg[5]);
            s2 = crp_pkg::WIDE_W'(term_reg[6]) + crp_pkg::WIDE_W'(term_reg[7]);
            s3 = crp_pkg::WIDE_W'(term_reg[8]) + crp_pkg::WIDE_W'(term_reg[9])
               + crp_pkg::WIDE_W'(term_reg[10]) + crp_pkg::WIDE_W'(term_reg[11]);

            // E1
            pe1_reg <= aux_reg[crp_pkg::DIV_STAGES-1];
            ir1_reg <= ir_next;
            // E2: raw products with ir
            pe2_reg  <= pe1_reg;
            ir2_reg  <= ir1_reg;
            pui_reg  <= crp_pkg::WIDE_W'(pe1_reg.u)   * crp_pkg::WIDE_W'(ir1_reg);
            pvi_reg  <= crp_pkg::WIDE_W'(pe1_reg.v)   * crp_pkg::WIDE_W'(ir1_reg);
            pti_reg  <= crp_pkg::WIDE_W'(pe1_reg.t)   * crp_pkg::WIDE_W'(ir1_reg);
            p01i_reg <= crp_pkg::WIDE_W'(pe1_reg.d01) * crp_pkg::WIDE_W'(ir1_reg);
            p02i_reg <= crp_pkg::WIDE_W'(pe1_reg.d02) * crp_pkg::WIDE_W'(ir1_reg);
            pgi_reg  <= crp_pkg::WIDE_W'(pe1_reg.gm1) * crp_pkg::WIDE_W'(ir1_reg);
            // E3: Jacobian entries that use ir
            pe3_reg <= pe2_reg;
            ir3_reg <= ir2_reg;
            d10_reg <= crp_pkg::neg_sat(crp_pkg::qmul_sat(pui_reg));
            d20_reg <= crp_pkg::neg_sat(crp_pkg::qmul_sat(pvi_reg));
            d30_reg <= crp_pkg::qmul_sat(pti_reg);
            d31_reg <= crp_pkg::qmul_sat(p01i_reg);
            d32_reg <= crp_pkg::qmul_sat(p02i_reg);
            d33_reg <= crp_pkg::qmul_sat(pgi_reg);
            // E4: matrix times residual, raw products
            err4_reg     <= pe3_reg.err;
            prod_reg[0]  <= crp_pkg::WIDE_W'(pe3_reg.d00) * crp_pkg::WIDE_W'(pe3_reg.a0);
            prod_reg[1]  <= crp_pkg::WIDE_W'(pe3_reg.d01) * crp_pkg::WIDE_W'(pe3_reg.a1);
            prod_reg[2]  <= crp_pkg::WIDE_W'(pe3_reg.d02) * crp_pkg::WIDE_W'(pe3_reg.a2);
            prod_reg[3]  <= crp_pkg::WIDE_W'(pe3_reg.gm1) * crp_pkg::WIDE_W'(pe3_reg.a3);
            prod_reg[4]  <= crp_pkg::WIDE_W'(d10_reg) * crp_pkg::WIDE_W'(pe3_reg.a0);
            prod_reg[5]  <= crp_pkg::WIDE_W'(ir3_reg) * crp_pkg::WIDE_W'(pe3_reg.a1);
            prod_reg[6]  <= crp_pkg::WIDE_W'(d20_reg) * crp_pkg::WIDE_W'(pe3_reg.a0);
            prod_reg[7]  <= crp_pkg::WIDE_W'(ir3_reg) * crp_pkg::WIDE_W'(pe3_reg.a2);
            prod_reg[8]  <= crp_pkg::WIDE_W'(d30_reg) * crp_pkg::WIDE_W'(pe3_reg.a0);
            prod_reg[9]  <= crp_pkg::WIDE_W'(d31_reg) * crp_pkg::WIDE_W'(pe3_reg.a1);
            prod_reg[10] <= crp_pkg::WIDE_W'(d32_reg) * crp_pkg::WIDE_W'(pe3_reg.a2);
            prod_reg[11] <= crp_pkg::WIDE_W'(d33_reg) * crp_pkg::WIDE_W'(pe3_reg.a3);
            // E5: scale and saturate each term
            err5_reg <= err4_reg;
            for (int i = 0; i < crp_pkg::NUM_TERMS; i++)
                term_reg[i] <= crp_pkg::qmul_sat(prod_reg[i]);
            // E6: row sums into the output register
            m_tuser_reg <= err5_reg;
            if (err5_reg)
                m_tdata_reg <= '0;
            else
                m_tdata_reg <= {crp_pkg::sat_wide(s3), crp_pkg::sat_wide(s2),
                                crp_pkg::sat_wide(s1), crp_pkg::sat_wide(s0)};
        end
    end

endmodule
